// ===== rtl/bacr_pkg.sv =====
`default_nettype none

package bacr_pkg;

    // default sizes
    localparam int SAMPLE_WIDTH    = 24;
    localparam int PHASE_FRAC_BITS = 24;

    // register file
    localparam int BIT_DEPTH_W = 5;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BIT_DEPTH = 2'd0,
        REG_PHASE_INC = 2'd1
    } cfg_reg_t;

    // status of the decision stage
    typedef struct packed {
        logic valid;
        logic take;
    } stage_t;

endpackage

`default_nettype wire

// ===== rtl/bacr_sample_in_if.sv =====
`default_nettype none

interface bacr_sample_in_if #(
    parameter int SAMPLE_WIDTH = bacr_pkg::SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/bacr_sample_out_if.sv =====
`default_nettype none

interface bacr_sample_out_if #(
    parameter int SAMPLE_WIDTH = bacr_pkg::SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/bacr_cfg_if.sv =====
`default_nettype none

interface bacr_cfg_if #(
    parameter int DATA_WIDTH = bacr_pkg::PHASE_FRAC_BITS + 1
);
    logic                               valid;
    logic                               ready;
    logic [bacr_pkg::CFG_INDEX_W-1:0]   reg_index;
    logic [DATA_WIDTH-1:0]              wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/bit_and_rate_crusher_top.sv =====
`default_nettype none

// channel  | role  | payload                  | request moves
// ---------+-------+--------------------------+--------------------------------
// din      | sink  | sample_in                | one audio sample
// dout     | source| sample_out               | one held, re-quantized sample
// cfg      | sink  | reg_index, wdata         | one register write
//
// one request in, one request out; a new sample can be taken every cycle unless both stages are full
// a sample passes the phase register stage, then the result register
// the phase adder with its compare and the shift-based quantizer set the path
// reset clears phase and held sample, bit depth 0 (bypass), increment 1.0
// the result register with its own valid lets din keep flowing while dout
// stalls; only when both stages are full does din.ready drop
// cfg is always ready; writes are registered

module bit_and_rate_crusher_top #(
    parameter int SAMPLE_WIDTH    = bacr_pkg::SAMPLE_WIDTH,
    parameter int PHASE_FRAC_BITS = bacr_pkg::PHASE_FRAC_BITS
) (
    input wire logic clk,
    input wire logic rst_n,
    bacr_sample_in_if.sink  din,
    bacr_sample_out_if.source dout,
    bacr_cfg_if.sink        cfg
);
    localparam logic [PHASE_FRAC_BITS:0] PHASE_ONE = {1'b1, {PHASE_FRAC_BITS{1'b0}}};

    // configuration registers
    logic [bacr_pkg::BIT_DEPTH_W-1:0] bit_depth_reg;
    logic [PHASE_FRAC_BITS:0]         phase_inc_reg;

    // pipeline
    logic                           out_ready;
    logic                           s1_ready;
    logic                           in_accept;
    logic                           s1_pop;
    bacr_pkg::stage_t               s1;
    logic signed [SAMPLE_WIDTH-1:0] s1_sample;
    logic signed [SAMPLE_WIDTH-1:0] quant;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] held_reg;

    // register writes, unknown index is dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_depth_reg <= '0;
            phase_inc_reg <= PHASE_ONE;
        end
        else if (cfg.valid)
        begin
            unique case (bacr_pkg::cfg_reg_t'(cfg.reg_index))
                bacr_pkg::REG_BIT_DEPTH: bit_depth_reg <= cfg.wdata[bacr_pkg::BIT_DEPTH_W-1:0];
                bacr_pkg::REG_PHASE_INC: phase_inc_reg <= cfg.wdata[PHASE_FRAC_BITS:0];
                default: ;
            endcase
        end
    end

    // ready chain: result slot frees when empty or drained
    assign out_ready = !out_valid_reg || dout.ready;
    assign s1_ready  = !s1.valid || out_ready;
    assign din.ready = s1_ready;
    assign in_accept = din.valid && s1_ready;
    assign s1_pop    = s1.valid && out_ready;

    // phase accumulator decides at acceptance whether this sample is taken
    bacr_phase #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_phase (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .sample       (din.sample_in),
        .increment    (phase_inc_reg),
        .pop          (s1_pop),
        .stage        (s1),
        .stage_sample (s1_sample)
    );

    // re-quantize the staged sample
    bacr_quant #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_quant (
        .bit_depth (bit_depth_reg),
        .x         (s1_sample),
        .y         (quant)
    );

    // held sample doubles as the result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else if (s1_pop)
        begin
            out_valid_reg <= 1'b1;
            if (s1.take)
            begin
                held_reg <= quant;
            end
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign dout.valid      = out_valid_reg;
    assign dout.sample_out = held_reg;

    // an accepted sample always occupies the decision stage next cycle
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1.valid)
        else $error("accepted sample did not reach decision stage");

    // a skipped sample repeats the held value
    a_skip_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_pop && !s1.take |=> $stable(held_reg))
        else $error("held sample changed on a skipped sample");

    // at full rate every sample is taken
    a_full_rate_takes: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (phase_inc_reg >= PHASE_ONE) |=> s1.take)
        else $error("sample not taken at full rate");

    // a stage pop always produces a result
    a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_pop |=> out_valid_reg)
        else $error("popped stage gave no result");

endmodule

`default_nettype wire

// ===== rtl/bacr_phase.sv =====
`default_nettype none

module bacr_phase #(
    parameter int SAMPLE_WIDTH    = bacr_pkg::SAMPLE_WIDTH,
    parameter int PHASE_FRAC_BITS = bacr_pkg::PHASE_FRAC_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    input  wire logic [PHASE_FRAC_BITS:0]       increment,
    input  wire logic                           pop,
    output bacr_pkg::stage_t                    stage,
    output logic signed [SAMPLE_WIDTH-1:0]      stage_sample
);
    localparam logic [PHASE_FRAC_BITS:0] PHASE_ONE = {1'b1, {PHASE_FRAC_BITS{1'b0}}};

    logic [PHASE_FRAC_BITS:0]       phase_reg, phase_next;
    logic [PHASE_FRAC_BITS:0]       inc_sat, sum;
    logic                           take;
    bacr_pkg::stage_t               stage_reg, stage_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;

    // phase stays below one, so the sum fits
    always_comb
    begin
        inc_sat    = (increment > PHASE_ONE) ? PHASE_ONE : increment;
        sum        = phase_reg + inc_sat;
        take       = sum[PHASE_FRAC_BITS];
        phase_next = {1'b0, sum[PHASE_FRAC_BITS-1:0]};
        stage_next = stage_reg;
        if (accept)
        begin
            stage_next.valid = 1'b1;
            stage_next.take  = take;
        end
        else if (pop)
        begin
            stage_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
            if (accept)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
        end
    end

    assign stage        = stage_reg;
    assign stage_sample = sample_reg;
endmodule

`default_nettype wire

// ===== rtl/bacr_quant.sv =====
`default_nettype none

module bacr_quant #(
    parameter int SAMPLE_WIDTH = bacr_pkg::SAMPLE_WIDTH
) (
    input  wire logic [bacr_pkg::BIT_DEPTH_W-1:0] bit_depth,
    input  wire logic signed [SAMPLE_WIDTH-1:0]   x,
    output logic signed [SAMPLE_WIDTH-1:0]        y
);
    localparam int SHW = $clog2(SAMPLE_WIDTH + 1);
    localparam int EW  = SAMPLE_WIDTH + 2;
    localparam logic signed [EW-1:0] QMAX = EW'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
    localparam logic signed [EW-1:0] QMIN = -QMAX - EW'(1);

    logic                  bypass;
    logic [SHW-1:0]        s;
    logic signed [EW-1:0]  xe;
    logic [EW-1:0]         mag, h, mask, q;
    logic signed [EW-1:0]  r, rs;

    // symmetric mid-rise: round magnitude to the step grid, offset by half a step
    always_comb
    begin
        bypass = (bit_depth == '0) || (32'(bit_depth) >= 32'(SAMPLE_WIDTH));
        s      = SHW'(SAMPLE_WIDTH) - SHW'(bit_depth);
        xe     = EW'(x);
        mag    = x[SAMPLE_WIDTH-1] ? EW'(-xe) : EW'(xe);
        h      = EW'(1) << (s - SHW'(1));
        mask   = ~((EW'(1) << s) - EW'(1));
        q      = (mag + h) & mask;
        r      = signed'(q - h);
        rs     = x[SAMPLE_WIDTH-1] ? -r : r;
        if (bypass)
        begin
            y = x;
        end
        else if (rs > QMAX)
        begin
            y = QMAX[SAMPLE_WIDTH-1:0];
        end
        else if (rs < QMIN)
        begin
            y = QMIN[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            y = rs[SAMPLE_WIDTH-1:0];
        end
    end
endmodule

`default_nettype wire

// ===== tb/bit_and_rate_crusher_top_tb.sv =====
`timescale 1ns / 100ps

module bit_and_rate_crusher_top_tb;
    import bacr_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int PW = PHASE_FRAC_BITS + 1;

    // 1.0 in the phase format, and the signed sample range
    localparam logic [PW-1:0]        PHASE_ONE  = PW'(1) << PHASE_FRAC_BITS;
    localparam logic [PW-1:0]        PHASE_FULL = {PW{1'b1}};
    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    // register indexes that decode to nothing
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    logic clk;
    logic rst_n;

    bacr_sample_in_if  din_if ();
    bacr_sample_out_if dout_if ();
    bacr_cfg_if        cfg_if ();

    bit_and_rate_crusher_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if),
        .cfg   (cfg_if)
    );

    // shadow of the block: register copies plus phase and held sample
    logic [BIT_DEPTH_W-1:0] depth_cfg    = '0;
    logic [PW-1:0]          rate_inc_cfg = PHASE_ONE;
    logic [PW-1:0]          phase_acc    = '0;
    logic signed [SW-1:0]   held_value   = '0;

    // crushed samples still owed by the block, oldest first
    logic signed [SW-1:0]   pending_crushed [$];

    // pacing controls shared by the stimulus and the sink
    bit din_offering      = 1'b0;
    bit sender_idle_on    = 1'b1;
    bit sink_stall_on     = 1'b1;
    int sink_hold_request = 0;

    int samples_sent    = 0;
    int samples_checked = 0;
    int error_count     = 0;
    int settings_used   = 0;
    int reg_writes      = 0;

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // symmetric mid-rise quantizer on the magnitude, step 2^(SW-depth)
    // depth 0 or at least the sample width passes the sample through
    function automatic logic signed [SW-1:0] requantize(input logic signed [SW-1:0] x,
                                                         input logic [BIT_DEPTH_W-1:0] depth);
        longint shift;
        longint half_step;
        longint mag;
        longint level;
        longint r;
        if (depth == 0 || depth >= SW)
            return x;
        shift     = SW - depth;
        half_step = longint'(1) << (shift - 1);
        mag       = (x < 0) ? -longint'(x) : longint'(x);
        level     = ((mag + half_step) >> shift) << shift;
        r         = level - half_step;
        if (x < 0)
            r = -r;
        // saturate to the signed range
        if (r > longint'(SAMPLE_MAX))
            r = longint'(SAMPLE_MAX);
        if (r < longint'(SAMPLE_MIN))
            r = longint'(SAMPLE_MIN);
        return r[SW-1:0];
    endfunction

    // advance the phase by one accepted sample and return the output sample
    function automatic logic signed [SW-1:0] crush_sample(input logic signed [SW-1:0] x);
        logic [PW-1:0] step_inc;
        // increments above 1.0 behave as full rate
        step_inc = (rate_inc_cfg > PHASE_ONE) ? PHASE_ONE : rate_inc_cfg;
        phase_acc = phase_acc + step_inc;
        if (phase_acc >= PHASE_ONE)
        begin
            phase_acc  = phase_acc - PHASE_ONE;
            held_value = requantize(x, depth_cfg);
        end
        return held_value;
    endfunction

    // ------------------------------------------------------------------
    // random choices
    // ------------------------------------------------------------------

    // mostly back to back, some short gaps, a few long ones
    function automatic int sender_gap();
        int roll;
        if (!sender_idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int sink_stall();
        int roll;
        if (!sink_stall_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // full-range noise, extremes, small values and values next to a
    // rounding threshold of the current depth
    function automatic logic signed [SW-1:0] random_sample();
        int pick;
        int shift;
        logic signed [SW-1:0] v;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            v = SW'($urandom);
        else if (pick == 5)
        begin
            case ($urandom_range(0, 4))
                0:       v = SAMPLE_MAX;
                1:       v = SAMPLE_MIN;
                2:       v = '0;
                3:       v = -1;
                default: v = 1;
            endcase
        end
        else if (pick < 8)
            v = SW'($urandom_range(0, 510)) - SW'(255);
        else if (depth_cfg != 0 && depth_cfg < SW)
        begin
            // thresholds sit at odd multiples of half a step
            shift = SW - depth_cfg;
            v = SW'($urandom) << shift;
            v = v + (SW'(1) << (shift - 1)) + SW'($urandom_range(0, 4)) - SW'(2);
            if ($urandom_range(0, 1))
                v = -v;
        end
        else
            v = SW'($urandom);
        return v;
    endfunction

    function automatic logic [BIT_DEPTH_W-1:0] random_depth();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 1;
            2:       return SW - 1;
            3:       return BIT_DEPTH_W'($urandom_range(SW, 31));
            default: return BIT_DEPTH_W'($urandom_range(2, SW - 2));
        endcase
    endfunction

    function automatic logic [PW-1:0] random_increment();
        case ($urandom_range(0, 9))
            0:       return PHASE_ONE;
            1:       return '0;
            2:       return PW'($urandom_range(PHASE_ONE + 1, PHASE_FULL));
            3:       return PW'($urandom_range(1, 255));
            4:       return PHASE_ONE - 1;
            default: return PW'($urandom_range(1, PHASE_ONE));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // offer one sample; valid stays high for a back-to-back follower
    task automatic send_sample(input logic signed [SW-1:0] value);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            if (din_offering)
                din_if.valid <= 1'b0;
            din_offering = 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_if.valid     <= 1'b1;
        din_if.sample_in <= value;
        din_offering = 1'b1;
        do
            @(posedge clk);
        while (din_if.ready !== 1'b1);
        pending_crushed.push_back(crush_sample(value));
        samples_sent++;
    endtask

    // drop the sample request and wait for every owed result
    task automatic wait_drained();
        if (din_offering)
            din_if.valid <= 1'b0;
        din_offering = 1'b0;
        do
            @(posedge clk);
        while (pending_crushed.size() != 0);
    endtask

    // write depth and increment, optionally also both undecoded indexes;
    // the depth write carries junk in its unused upper bits half the time
    task automatic configure(input logic [BIT_DEPTH_W-1:0] depth,
                             input logic [PW-1:0] inc,
                             input bit with_spare);
        logic [CFG_INDEX_W-1:0] index [4];
        logic [PW-1:0]          data  [4];
        int                     count;
        index[0] = REG_BIT_DEPTH;
        data[0]  = $urandom_range(0, 1) ? PW'($urandom) : '0;
        data[0][BIT_DEPTH_W-1:0] = depth;
        index[1] = REG_PHASE_INC;
        data[1]  = inc;
        index[2] = REG_SPARE_A;
        data[2]  = PW'($urandom);
        index[3] = REG_SPARE_B;
        data[3]  = PW'($urandom);
        count    = with_spare ? 4 : 2;
        for (int i = 0; i < count; i++)
        begin
            cfg_if.valid     <= 1'b1;
            cfg_if.reg_index <= index[i];
            cfg_if.wdata     <= data[i];
            do
                @(posedge clk);
            while (cfg_if.ready !== 1'b1);
            case (index[i])
                REG_BIT_DEPTH: depth_cfg    = data[i][BIT_DEPTH_W-1:0];
                REG_PHASE_INC: rate_inc_cfg = data[i];
                default: ;
            endcase
            reg_writes++;
        end
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // sink pacing: random stalls, or one long hold-off when asked for
    initial
    begin : sink_pacing
        int hold_len;
        dout_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (sink_hold_request > 0)
            begin
                hold_len = sink_hold_request;
                sink_hold_request = 0;
            end
            else
                hold_len = sink_stall();
            if (hold_len > 0)
            begin
                dout_if.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
            end
            dout_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // compare every accepted output request with the oldest owed sample
    always @(posedge clk)
    begin : check_results
        logic signed [SW-1:0] want;
        if (rst_n && dout_if.valid === 1'b1 && dout_if.ready === 1'b1)
        begin
            if (pending_crushed.size() == 0)
                report_error($sformatf("unexpected output sample %0d", dout_if.sample_out));
            else
            begin
                want = pending_crushed.pop_front();
                if (dout_if.sample_out !== want)
                    report_error($sformatf("output %0d: expected %0d got %0d",
                                           samples_checked, want, dout_if.sample_out));
                samples_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset state: bypass at full rate, so samples come straight back
    task automatic test_bypass_after_reset();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(24'sh555555);
        send_sample(24'shAAAAAA);
        send_sample('0);
    endtask

    // coarsest and finest depths, plus depths that mean bypass
    task automatic test_quantizer_depths();
        wait_drained();
        // one bit: every sample lands on plus or minus half scale
        configure(1, PHASE_ONE, 1'b0);
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        wait_drained();
        // finest real quantization: step of two, zero maps to minus one
        configure(SW - 1, PHASE_ONE, 1'b0);
        send_sample('0);
        send_sample(1);
        send_sample(-2);
        send_sample(3);
        wait_drained();
        configure(SW, PHASE_ONE, 1'b0);
        send_sample(SAMPLE_MIN);
        wait_drained();
        configure(31, PHASE_ONE, 1'b0);
        send_sample(SAMPLE_MAX);
    endtask

    // zero increment holds forever; increments above 1.0 act as full rate
    task automatic test_rate_extremes();
        wait_drained();
        configure(0, '0, 1'b0);
        send_sample(24'sh123456);
        send_sample(-24'sh0ABCDE);
        send_sample(SAMPLE_MAX);
        wait_drained();
        configure(0, PHASE_FULL, 1'b0);
        send_sample(24'sh7F0F0F);
        send_sample(-24'sh00F0F1);
        wait_drained();
        configure(0, PHASE_ONE + 1, 1'b0);
        send_sample(24'sh010203);
    endtask

    // writes to undecoded indexes must leave both registers alone
    task automatic test_spare_index();
        wait_drained();
        configure(4, PHASE_ONE >> 1, 1'b1);
        send_sample(24'sh3C3C3C);
        send_sample(-24'sh3C3C3C);
    endtask

    // sink holds off for a long stretch while samples keep coming, so
    // both internal stages fill and din.ready has to drop
    task automatic test_backpressure();
        wait_drained();
        configure(BIT_DEPTH_W'($urandom_range(1, SW - 1)), PHASE_ONE, 1'b0);
        sender_idle_on    = 1'b0;
        sink_stall_on     = 1'b0;
        sink_hold_request = 200;
        for (int i = 0; i < 60; i++)
            send_sample(random_sample());
        wait_drained();
        sender_idle_on = 1'b1;
        sink_stall_on  = 1'b1;
    endtask

    // random settings, each with a long run of random samples; some
    // runs without any idling on one or both sides
    task automatic test_random_settings();
        for (int set = 0; set < 8; set++)
        begin
            wait_drained();
            configure(random_depth(), random_increment(), $urandom_range(0, 3) == 0);
            sender_idle_on = $urandom_range(0, 3) != 0;
            sink_stall_on  = $urandom_range(0, 3) != 0;
            for (int i = 0; i < 250; i++)
                send_sample(random_sample());
        end
        sender_idle_on = 1'b1;
        sink_stall_on  = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n            = 1'b0;
        din_if.valid     = 1'b0;
        din_if.sample_in = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.reg_index = REG_BIT_DEPTH;
        cfg_if.wdata     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_bypass_after_reset();
        test_quantizer_depths();
        test_rate_extremes();
        test_spare_index();
        test_backpressure();
        test_random_settings();

        // let the pipeline settle, then make sure nothing is left owed
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_crushed.size() != 0)
            report_error($sformatf("%0d output samples never arrived",
                                   pending_crushed.size()));

        $display("checked %0d of %0d samples under %0d register settings (%0d writes)",
                 samples_checked, samples_sent, settings_used, reg_writes);
        $display("depths 0 to 31, increments from zero to above full rate, long sink hold-off");
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hard stop if the run hangs
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
